>>> design/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, request codes, payload structs and FSM states for the
// Life generation engine.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Grid size
    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;

    // Derived widths
    localparam int COL_W     = $clog2(GRID_COLUMNS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int RAM_DEPTH = 2 * GRID_ROWS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int CNT_W     = $clog2(GRID_ROWS + 3);
    localparam int ROWCNT_W  = $clog2(GRID_COLUMNS + 1);
    localparam int ACC_W     = $clog2(GRID_COLUMNS * GRID_ROWS + 1);
    localparam int LIVE_W    = 13;
    localparam int SAT_W     = (ACC_W > LIVE_W) ? ACC_W : LIVE_W;
    localparam int COUNT_MAX = 8191;

    // B3/S23 rule
    localparam int SURVIVE_COUNT = 2;
    localparam int BIRTH_COUNT   = 3;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_value;
    } req_t;

    typedef struct packed {
        logic              read_value;
        logic [LIVE_W-1:0] live_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_FINISH
    } state_t;

endpackage

>>> design/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/lgs_row_eval.sv
// ----------------------------------------------------------------------------
// lgs_row_eval
// Next-generation value of one full row from the rows above, at and below
// it. Columns outside the grid count as dead.
// ----------------------------------------------------------------------------
module lgs_row_eval (
    input  logic [lgs_pkg::GRID_COLUMNS-1:0] above,
    input  logic [lgs_pkg::GRID_COLUMNS-1:0] mid,
    input  logic [lgs_pkg::GRID_COLUMNS-1:0] below,
    output logic [lgs_pkg::GRID_COLUMNS-1:0] next_row
);

    logic [lgs_pkg::GRID_COLUMNS+1:0] a_ext;
    logic [lgs_pkg::GRID_COLUMNS+1:0] m_ext;
    logic [lgs_pkg::GRID_COLUMNS+1:0] b_ext;

    // dead border on both sides
    assign a_ext = {1'b0, above, 1'b0};
    assign m_ext = {1'b0, mid,   1'b0};
    assign b_ext = {1'b0, below, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        n = '0;
        for (int c = 0; c < lgs_pkg::GRID_COLUMNS; c++)
        begin
            n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
              + 4'(m_ext[c])                  + 4'(m_ext[c+2])
              + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
            next_row[c] = (n == 4'(lgs_pkg::BIRTH_COUNT))
                        || (mid[c] && (n == 4'(lgs_pkg::SURVIVE_COUNT)));
        end
    end

endmodule

>>> design/life_generation_step.sv
// ----------------------------------------------------------------------------
// life_generation_step
// Conway Life engine (B3/S23) on a bounded, double-buffered bit grid.
// ----------------------------------------------------------------------------
// Both buffers live in one RAM of 2*GRID_ROWS rows, each row GRID_COLUMNS
// cells wide; the active buffer bit picks the half. One item is handled at a
// time. A cell write is a read-modify-write of its row and a cell read fetches
// the row; both then go through the cell state and the finish state. A step
// streams the active half through the single RAM read port, one row per
// cycle, keeps a three-row window, evaluates a whole row at once and writes
// it into the other half in the next cycle while its live cells are added
// up. Results sit in an output register, so a waiting result never blocks
// the engine from finishing the next item's work up to delivery. Reset
// clearing of both buffers is done with one valid flop per RAM row: a row
// never written reads as all dead, so no clearing pass is needed. The live
// count saturates at 8191.
// ----------------------------------------------------------------------------
module life_generation_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lgs_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lgs_pkg::rsp_t  rsp
);

    localparam int COLS = lgs_pkg::GRID_COLUMNS;
    localparam int ROWS = lgs_pkg::GRID_ROWS;

    // control state
    lgs_pkg::state_t                state_reg, state_next;
    logic                           active_reg, active_next;
    logic [lgs_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           nxt_valid_reg, nxt_valid_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic                           rd_valid_reg;
    logic [lgs_pkg::RAM_DEPTH-1:0]  row_valid_reg;

    // payload
    lgs_pkg::req_t                  req_reg, req_next;
    logic [COLS-1:0]                prev_reg, prev_next;
    logic [COLS-1:0]                cur_reg, cur_next;
    logic [COLS-1:0]                nxt_reg, nxt_next;
    logic [lgs_pkg::ROW_W-1:0]      nxt_row_reg, nxt_row_next;
    logic [lgs_pkg::ACC_W-1:0]      acc_reg, acc_next;
    lgs_pkg::rsp_t                  res_reg, res_next;
    lgs_pkg::rsp_t                  rsp_reg, rsp_next;

    // RAM ports
    logic                           ram_wr_en;
    logic [lgs_pkg::RAM_AW-1:0]     ram_wr_addr;
    logic [COLS-1:0]                ram_wr_data;
    logic                           ram_rd_en;
    logic [lgs_pkg::RAM_AW-1:0]     ram_rd_addr;
    logic [COLS-1:0]                ram_rd_data;

    logic [COLS-1:0]                row_data;
    logic [COLS-1:0]                new_row;
    logic [COLS-1:0]                eval_row;
    logic [lgs_pkg::COL_W-1:0]      col_idx;
    logic [lgs_pkg::ROW_W-1:0]      cell_row;
    logic                           cell_inside;
    logic [lgs_pkg::ROWCNT_W-1:0]   row_pop;
    logic [lgs_pkg::SAT_W-1:0]      acc_ext;
    logic [lgs_pkg::LIVE_W-1:0]     live_sat;

    // buffer half + row -> RAM address
    function automatic logic [lgs_pkg::RAM_AW-1:0] row_addr(
        input logic                      buf_sel,
        input logic [lgs_pkg::ROW_W-1:0] row
    );
        logic [lgs_pkg::RAM_AW-1:0] base;
        base = buf_sel ? lgs_pkg::RAM_AW'(ROWS) : '0;
        return base + lgs_pkg::RAM_AW'(row);
    endfunction

    lgs_ram #(
        .WIDTH (COLS),
        .DEPTH (lgs_pkg::RAM_DEPTH)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lgs_row_eval u_eval (
        .above    (prev_reg),
        .mid      (cur_reg),
        .below    (new_row),
        .next_row (eval_row)
    );

    // rows never written since reset read as dead
    assign row_data = rd_valid_reg ? ram_rd_data : '0;

    assign col_idx     = lgs_pkg::COL_W'(req_reg.cell_x);
    assign cell_row    = lgs_pkg::ROW_W'(req_reg.cell_y);
    assign cell_inside = (32'(req_reg.cell_x) < 32'(COLS))
                      && (32'(req_reg.cell_y) < 32'(ROWS));

    assign row_pop  = lgs_pkg::ROWCNT_W'($countones(nxt_reg));
    assign acc_ext  = lgs_pkg::SAT_W'(acc_reg);
    assign live_sat = (acc_ext > lgs_pkg::SAT_W'(lgs_pkg::COUNT_MAX))
                    ? lgs_pkg::LIVE_W'(lgs_pkg::COUNT_MAX)
                    : acc_ext[lgs_pkg::LIVE_W-1:0];

    assign req_ready = (state_reg == lgs_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        nxt_valid_next = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        nxt_row_next   = nxt_row_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        new_row        = '0;

        ram_rd_en   = 1'b0;
        ram_rd_addr = row_addr(active_reg, lgs_pkg::ROW_W'(req.cell_y));
        ram_wr_en   = 1'b0;
        ram_wr_addr = row_addr(active_reg, cell_row);
        ram_wr_data = row_data;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.req_type)
                        lgs_pkg::REQ_WRITE,
                        lgs_pkg::REQ_READ:
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = lgs_pkg::ST_CELL;
                        end
                        lgs_pkg::REQ_STEP:
                        begin
                            cnt_next   = '0;
                            prev_next  = '0;
                            cur_next   = '0;
                            acc_next   = '0;
                            state_next = lgs_pkg::ST_STEP;
                        end
                        default:
                        begin
                            // unused code: no effect, all-zero result
                            res_next   = '0;
                            state_next = lgs_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            lgs_pkg::ST_CELL:
            begin
                res_next = '0;
                if (req_reg.req_type == lgs_pkg::REQ_WRITE)
                begin
                    if (cell_inside)
                    begin
                        ram_wr_en            = 1'b1;
                        ram_wr_data[col_idx] = req_reg.cell_value;
                    end
                end
                else
                begin
                    res_next.read_value = cell_inside && row_data[col_idx];
                end
                state_next = lgs_pkg::ST_FINISH;
            end

            lgs_pkg::ST_STEP:
            begin
                // issue source row cnt
                if (cnt_reg < lgs_pkg::CNT_W'(ROWS))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = row_addr(active_reg, lgs_pkg::ROW_W'(cnt_reg));
                end
                // row cnt-1 arrives; past the last row the window sees dead cells
                if ((cnt_reg >= lgs_pkg::CNT_W'(1)) && (cnt_reg <= lgs_pkg::CNT_W'(ROWS)))
                begin
                    new_row = row_data;
                end
                if ((cnt_reg >= lgs_pkg::CNT_W'(1)) && (cnt_reg <= lgs_pkg::CNT_W'(ROWS + 1)))
                begin
                    prev_next = cur_reg;
                    cur_next  = new_row;
                end
                // window centered on row cnt-2
                if ((cnt_reg >= lgs_pkg::CNT_W'(2)) && (cnt_reg <= lgs_pkg::CNT_W'(ROWS + 1)))
                begin
                    nxt_next       = eval_row;
                    nxt_row_next   = lgs_pkg::ROW_W'(cnt_reg - lgs_pkg::CNT_W'(2));
                    nxt_valid_next = 1'b1;
                end
                // write back the evaluated row into the other half
                if (nxt_valid_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = row_addr(!active_reg, nxt_row_reg);
                    ram_wr_data = nxt_reg;
                    acc_next    = acc_reg + lgs_pkg::ACC_W'(row_pop);
                end
                cnt_next = cnt_reg + lgs_pkg::CNT_W'(1);
                if (cnt_reg == lgs_pkg::CNT_W'(ROWS + 2))
                begin
                    active_next = !active_reg;
                    state_next  = lgs_pkg::ST_FINISH;
                end
            end

            lgs_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (req_reg.req_type == lgs_pkg::REQ_STEP)
                    begin
                        rsp_next.read_value = 1'b0;
                        rsp_next.live_count = live_sat;
                    end
                    else
                    begin
                        rsp_next = res_reg;
                    end
                    state_next = lgs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgs_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            nxt_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            nxt_valid_reg <= nxt_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ram_rd_en)
            begin
                rd_valid_reg <= row_valid_reg[ram_rd_addr];
            end
            if (ram_wr_en)
            begin
                row_valid_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        nxt_row_reg <= nxt_row_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    // no same-row read and write in one cycle: the RAM has no bypass
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("RAM read and write hit the same row");

    // step writes only go to the inactive half
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lgs_pkg::ST_STEP) && ram_wr_en)
            |-> ((ram_wr_addr >= lgs_pkg::RAM_AW'(ROWS)) == !active_reg))
        else $error("step wrote into the active buffer");

    // buffer swap only at the end of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(active_reg) |-> ($past(state_reg) == lgs_pkg::ST_STEP))
        else $error("active buffer changed outside a step");

    // live count cannot exceed the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lgs_pkg::ST_FINISH) && (req_reg.req_type == lgs_pkg::REQ_STEP))
            |-> (32'(acc_reg) <= 32'(COLS * ROWS)))
        else $error("live count above grid size");

    // a new result only comes from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == lgs_pkg::ST_FINISH))
        else $error("result raised outside finish");

endmodule
